@@ rtl/xsa_pkg.sv @@
package xsa_pkg;

    // Store and lane geometry
    localparam int SECRET_WORDS = 32;
    localparam int LANES        = 8;
    localparam int SIDX_W       = $clog2(SECRET_WORDS);
    localparam int LANE_W       = $clog2(LANES);
    localparam int ROWS         = LANES / 2;        // one row holds a lane pair
    localparam int ROW_AW       = LANE_W - 1;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int ROW_W  = 2 * WORD_W;

    // stripe, secret_index and scramble_base fields
    localparam int FIELD_IDX_W = 5;
    localparam int SUM_W       = FIELD_IDX_W + 1;

    localparam int                        SCRAMBLE_SHIFT      = 47;
    localparam logic [HALF_W-1:0]         PRIME32_1           = 32'h9E3779B1;
    localparam logic [FIELD_IDX_W-1:0]    SCRAMBLE_BASE_RESET = 5'd16;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_LOAD     = 2'd0,
        MODE_ACCUM    = 2'd1,
        MODE_SCRAMBLE = 2'd2,
        MODE_WRITE    = 2'd3
    } t_mode;

    typedef struct packed {
        logic              s1_valid;
        logic              s2_valid;
        logic              s1_writes;
        logic [ROW_AW-1:0] s1_row;
    } t_pipe_status;

    // index sums stay below 2 * SECRET_WORDS + 8, two folds are enough
    function automatic logic [SIDX_W-1:0] secret_wrap(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] v;
        v = sum;
        if (int'(v) >= SECRET_WORDS) begin
            v = v - SUM_W'(SECRET_WORDS);
        end
        if (int'(v) >= SECRET_WORDS) begin
            v = v - SUM_W'(SECRET_WORDS);
        end
        return SIDX_W'(v);
    endfunction

endpackage

@@ rtl/xsa_secret_mem.sv @@
module xsa_secret_mem (
    input  logic                                i_clk,
    input  logic                                i_accept,
    input  xsa_pkg::t_mode                      i_mode,
    input  logic [xsa_pkg::WORD_W-1:0]          i_data_word,
    input  logic [xsa_pkg::LANE_W-1:0]          i_lane,
    input  logic [xsa_pkg::FIELD_IDX_W-1:0]     i_stripe,
    input  logic [xsa_pkg::FIELD_IDX_W-1:0]     i_secret_index,
    input  logic [xsa_pkg::FIELD_IDX_W-1:0]     i_scramble_base,
    output logic [xsa_pkg::WORD_W-1:0]          o_secret
);

    logic [xsa_pkg::WORD_W-1:0] r_mem [xsa_pkg::SECRET_WORDS];
    logic [xsa_pkg::WORD_W-1:0] r_rdata;
    logic [xsa_pkg::SUM_W-1:0]  idx_sum;
    logic [xsa_pkg::SIDX_W-1:0] rd_addr;
    logic                       wr_en;

    // scramble keys start at the base register, accumulate keys at the stripe
    always_comb begin
        if (i_mode == xsa_pkg::MODE_SCRAMBLE) begin
            idx_sum = xsa_pkg::SUM_W'(i_scramble_base) + xsa_pkg::SUM_W'(i_lane);
        end else begin
            idx_sum = xsa_pkg::SUM_W'(i_stripe) + xsa_pkg::SUM_W'(i_lane);
        end
        rd_addr = xsa_pkg::secret_wrap(idx_sum);
        wr_en   = i_accept && (i_mode == xsa_pkg::MODE_LOAD)
                  && (int'(i_secret_index) < xsa_pkg::SECRET_WORDS);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[xsa_pkg::SIDX_W'(i_secret_index)] <= i_data_word;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign o_secret = r_rdata;

endmodule

@@ rtl/xsa_acc_pipe.sv @@
module xsa_acc_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  xsa_pkg::t_mode                i_mode,
    input  logic [xsa_pkg::WORD_W-1:0]    i_data_word,
    input  logic [xsa_pkg::LANE_W-1:0]    i_lane,
    input  logic [xsa_pkg::WORD_W-1:0]    i_secret,
    output xsa_pkg::t_pipe_status         o_status,
    output logic                          o_res_valid,
    output logic [xsa_pkg::WORD_W-1:0]    o_res_word
);

    localparam int W  = xsa_pkg::WORD_W;
    localparam int H  = xsa_pkg::HALF_W;
    localparam int RW = xsa_pkg::ROW_W;
    localparam int RA = xsa_pkg::ROW_AW;
    localparam int LW = xsa_pkg::LANE_W;

    // accumulator pairs, one row per pair
    logic [RW-1:0]            r_mem [xsa_pkg::ROWS];
    logic [xsa_pkg::ROWS-1:0] r_row_v;
    logic [RW-1:0]            r_rd_row;
    logic                     r_rd_v;

    // last row written, covers the read that raced with it
    logic          r_lw_v;
    logic [RA-1:0] r_lw_idx;
    logic [RW-1:0] r_lw_data;

    logic           r_s1_v;
    xsa_pkg::t_mode r_s1_mode;
    logic [LW-1:0]  r_s1_lane;
    logic [W-1:0]   r_s1_data;

    logic           r_s2_v;
    xsa_pkg::t_mode r_s2_mode;
    logic [LW-1:0]  r_s2_lane;
    logic [W-1:0]   r_s2_data;
    logic [RW-1:0]  r_s2_row;
    logic [W-1:0]   r_s2_pa;
    logic [H-1:0]   r_s2_pb;

    logic [RA-1:0] s1_idx, s2_idx;
    logic          s2_we;
    logic [RW-1:0] row_base, row_s1, s2_row_new;
    logic [W-1:0]  sc_a, sc_x, dk;
    logic [H-1:0]  mul_op0, mul_op1;
    logic [W-1:0]  mul_a;
    logic [H-1:0]  mul_b;
    logic [W-1:0]  own_old, other_old, own_new, other_new;

    assign s1_idx = r_s1_lane[LW-1:1];
    assign s2_idx = r_s2_lane[LW-1:1];
    assign s2_we  = r_s2_v && (r_s2_mode != xsa_pkg::MODE_LOAD);

    // stage 1: forward, then multiply
    always_comb begin
        if (r_lw_v && (r_lw_idx == s1_idx)) begin
            row_base = r_lw_data;
        end else if (r_rd_v) begin
            row_base = r_rd_row;
        end else begin
            row_base = '0;
        end
        // the write in flight in stage 2 only feeds the stage-2 row, scramble is interlocked
        row_s1 = (s2_we && (s2_idx == s1_idx)) ? s2_row_new : row_base;

        sc_a = r_s1_lane[0] ? row_base[RW-1:W] : row_base[W-1:0];
        sc_x = sc_a ^ (sc_a >> xsa_pkg::SCRAMBLE_SHIFT) ^ i_secret;
        dk   = r_s1_data ^ i_secret;

        if (r_s1_mode == xsa_pkg::MODE_SCRAMBLE) begin
            mul_op0 = sc_x[H-1:0];
            mul_op1 = xsa_pkg::PRIME32_1;
        end else begin
            mul_op0 = dk[H-1:0];
            mul_op1 = dk[W-1:H];
        end
        mul_a = W'(mul_op0) * W'(mul_op1);
        mul_b = sc_x[W-1:H] * xsa_pkg::PRIME32_1;
    end

    // stage 2: adds and row assembly
    always_comb begin
        own_old   = r_s2_lane[0] ? r_s2_row[RW-1:W] : r_s2_row[W-1:0];
        other_old = r_s2_lane[0] ? r_s2_row[W-1:0]  : r_s2_row[RW-1:W];
        other_new = other_old;
        unique case (r_s2_mode)
            xsa_pkg::MODE_LOAD: begin
                own_new = own_old;
            end
            xsa_pkg::MODE_ACCUM: begin
                own_new   = own_old + r_s2_pa;
                other_new = other_old + r_s2_data;
            end
            xsa_pkg::MODE_SCRAMBLE: begin
                own_new = r_s2_pa + {r_s2_pb, {H{1'b0}}};
            end
            xsa_pkg::MODE_WRITE: begin
                own_new = r_s2_data;
            end
        endcase
        s2_row_new = r_s2_lane[0] ? {own_new, other_new} : {other_new, own_new};
    end

    always_ff @(posedge i_clk) begin
        r_rd_row <= r_mem[i_lane[LW-1:1]];
        r_rd_v   <= r_row_v[i_lane[LW-1:1]];
        if (s2_we) begin
            r_mem[s2_idx] <= s2_row_new;
            r_lw_idx      <= s2_idx;
            r_lw_data     <= s2_row_new;
        end
        if (i_accept) begin
            r_s1_mode <= i_mode;
            r_s1_lane <= i_lane;
            r_s1_data <= i_data_word;
        end
        if (r_s1_v) begin
            r_s2_mode <= r_s1_mode;
            r_s2_lane <= r_s1_lane;
            r_s2_data <= r_s1_data;
            r_s2_row  <= row_s1;
            r_s2_pa   <= mul_a;
            r_s2_pb   <= mul_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_v <= '0;
            r_lw_v  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
        end else begin
            if (s2_we) begin
                r_row_v[s2_idx] <= 1'b1;
                r_lw_v          <= 1'b1;
            end
            r_s1_v <= i_accept;
            r_s2_v <= r_s1_v;
        end
    end

    assign o_status.s1_valid  = r_s1_v;
    assign o_status.s2_valid  = r_s2_v;
    assign o_status.s1_writes = r_s1_v && (r_s1_mode != xsa_pkg::MODE_LOAD);
    assign o_status.s1_row    = s1_idx;

    assign o_res_valid = r_s2_v;
    assign o_res_word  = own_new;

endmodule

@@ rtl/xsa_out_fifo.sv @@
module xsa_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [xsa_pkg::WORD_W-1:0]    i_word,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [xsa_pkg::WORD_W-1:0]    o_word,
    output logic [xsa_pkg::CNT_W-1:0]     o_count
);

    localparam int AW = xsa_pkg::FIFO_AW;

    logic [xsa_pkg::WORD_W-1:0] r_mem [xsa_pkg::FIFO_DEPTH];
    logic [AW-1:0]              r_wr_ptr, r_rd_ptr;
    logic [xsa_pkg::CNT_W-1:0]  r_cnt;
    logic                       pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(xsa_pkg::FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign o_count = r_cnt;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_cnt <= r_cnt + xsa_pkg::CNT_W'(i_push) - xsa_pkg::CNT_W'(pop);
        end
    end

endmodule

@@ rtl/xxh3_stripe_accumulator_unit.sv @@
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+---------------------------------------
// in        | request   | i_in_valid / o_in_stall | i_mode i_data_word i_lane i_stripe
//           |           |                         | i_secret_index
// out       | result    | o_out_valid / i_out_stall | o_acc_word
// cfg       | write     | i_cfg_we                | i_cfg_data (scramble_base)
//
// One request per cycle sustained while o_in_stall is low; each result passes the
// secret/row read, multiply, and add and write-back in order before it enters the output queue.
// A scramble is held while the request just ahead writes the same lane pair.
// Four-entry result queue: requests keep flowing until four are outstanding.
// Reset (sync, active low): accumulators read zero through per-pair valid bits,
// no clearing pass; scramble_base returns to 16.
module xxh3_stripe_accumulator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [xsa_pkg::FIELD_IDX_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_mode,
    input  logic [xsa_pkg::WORD_W-1:0]          i_data_word,
    input  logic [xsa_pkg::LANE_W-1:0]          i_lane,
    input  logic [xsa_pkg::FIELD_IDX_W-1:0]     i_stripe,
    input  logic [xsa_pkg::FIELD_IDX_W-1:0]     i_secret_index,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [xsa_pkg::WORD_W-1:0]          o_acc_word
);

    logic [xsa_pkg::FIELD_IDX_W-1:0] r_scramble_base;

    xsa_pkg::t_mode        mode;
    xsa_pkg::t_pipe_status pipe_st;
    logic                  accept;
    logic                  hazard;
    logic                  room;
    logic [xsa_pkg::CNT_W-1:0] q_count;
    logic [xsa_pkg::CNT_W-1:0] pending;
    logic [xsa_pkg::WORD_W-1:0] secret;
    logic                  res_valid;
    logic [xsa_pkg::WORD_W-1:0] res_word;

    assign mode = xsa_pkg::t_mode'(i_mode);

    // Scramble needs its lane before the multiply, so it cannot take the
    // stage-2 add result by forwarding; hold it at the input instead.
    assign hazard = (mode == xsa_pkg::MODE_SCRAMBLE) && pipe_st.s1_writes
                    && (pipe_st.s1_row == i_lane[xsa_pkg::LANE_W-1:1]);

    // Every request in the pipe has a queue slot reserved, so the pipe never stalls.
    assign pending = q_count + xsa_pkg::CNT_W'(pipe_st.s1_valid)
                     + xsa_pkg::CNT_W'(pipe_st.s2_valid);
    assign room    = (int'(pending) < xsa_pkg::FIFO_DEPTH);

    assign o_in_stall = !room || hazard;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scramble_base <= xsa_pkg::SCRAMBLE_BASE_RESET;
        end else if (i_cfg_we) begin
            r_scramble_base <= i_cfg_data;
        end
    end

    xsa_secret_mem u_secret (
        .i_clk           (i_clk),
        .i_accept        (accept),
        .i_mode          (mode),
        .i_data_word     (i_data_word),
        .i_lane          (i_lane),
        .i_stripe        (i_stripe),
        .i_secret_index  (i_secret_index),
        .i_scramble_base (r_scramble_base),
        .o_secret        (secret)
    );

    xsa_acc_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_mode      (mode),
        .i_data_word (i_data_word),
        .i_lane      (i_lane),
        .i_secret    (secret),
        .o_status    (pipe_st),
        .o_res_valid (res_valid),
        .o_res_word  (res_word)
    );

    xsa_out_fifo u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_word  (res_word),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_word  (o_acc_word),
        .o_count (q_count)
    );

endmodule

@@ rtl/xsa_checker.sv @@
module xsa_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_we,
    input logic [xsa_pkg::FIELD_IDX_W-1:0]     i_cfg_data,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic [1:0]                          i_mode,
    input logic [xsa_pkg::WORD_W-1:0]          i_data_word,
    input logic [xsa_pkg::LANE_W-1:0]          i_lane,
    input logic [xsa_pkg::FIELD_IDX_W-1:0]     i_stripe,
    input logic [xsa_pkg::FIELD_IDX_W-1:0]     i_secret_index,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [xsa_pkg::WORD_W-1:0]          o_acc_word
);

    localparam int PW = xsa_pkg::CNT_W + 1;

    logic          in_acc, out_acc;
    logic [PW-1:0] r_pend;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // requests accepted and not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + PW'(in_acc) - PW'(out_acc);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pend != '0))
        else $error("result delivered without an outstanding request");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PW'(xsa_pkg::FIFO_DEPTH))
        else $error("more requests outstanding than the result queue holds");

    a_write_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_mode == xsa_pkg::MODE_WRITE) && (r_pend == '0))
        |-> ##3 (o_out_valid && (o_acc_word == $past(i_data_word, 3))))
        else $error("lane write on an idle unit not returned after three cycles");

    // configuration and remaining payload are not checked here
    logic unused_ok;
    assign unused_ok = i_cfg_we ^ (^i_cfg_data) ^ (^i_lane) ^ (^i_stripe)
                       ^ (^i_secret_index);

endmodule

bind xxh3_stripe_accumulator_unit xsa_checker u_xsa_checker (.*);
